// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// They rely on clk_i and rst_ni in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The expression must never be true outside reset.
`define SHA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/sha256_pkg.sv =====
package sha256_pkg;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned Rounds    = 64;

  typedef logic [7:0][31:0] hash_t;

  // input op codes
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_COMP,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start; // latch block, begin 64 rounds
    logic init;  // reload initial hash values
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;  // high in the cycle the hash words are updated
  } core_stat_t;

endpackage

// ===== hw/rtl/sha256_core.sv =====
module sha256_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sha256_pkg::core_ctrl_t             ctrl_i,
  input  logic [sha256_pkg::BlockBits-1:0]   block_i,
  output sha256_pkg::core_stat_t             stat_o,
  output sha256_pkg::hash_t                  hash_o
);
  import sha256_pkg::*;

  localparam logic [5:0] RndLast = 6'(Rounds - 1);

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] h_q [8];
  logic [31:0] v_q [8], v_d [8];
  logic [31:0] w_q [16], w_d [16];
  logic [5:0]  rnd_q;
  logic        busy_q, add_q;

  logic [31:0] s0, s1, bs0, bs1, ch, maj, t1, t2, w_new;

  // one round and one schedule step per cycle while busy
  always_comb begin
    s0    = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
    s1    = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = s1 + w_q[9] + s0 + w_q[0];
    bs1   = ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25);
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1    = v_q[7] + bs1 + ch + K[rnd_q] + w_q[0];
    bs0   = ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2    = bs0 + maj;
    v_d[0] = t1 + t2;
    v_d[1] = v_q[0];
    v_d[2] = v_q[1];
    v_d[3] = v_q[2];
    v_d[4] = v_q[3] + t1;
    v_d[5] = v_q[4];
    v_d[6] = v_q[5];
    v_d[7] = v_q[6];
    for (int j = 0; j < 15; j++) begin
      w_d[j] = w_q[j+1];
    end
    w_d[15] = w_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      add_q  <= 1'b0;
      rnd_q  <= '0;
      for (int j = 0; j < 8; j++) h_q[j] <= IV[j];
    end else begin
      add_q <= 1'b0;
      if (ctrl_i.init) begin
        for (int j = 0; j < 8; j++) h_q[j] <= IV[j];
      end
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == RndLast) begin
          busy_q <= 1'b0;
          add_q  <= 1'b1;
        end
      end
      if (add_q) begin
        for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
      end
    end
  end

  // working variables and schedule window: no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
      for (int j = 0; j < 16; j++) w_q[j] <= block_i[BlockBits - 1 - 32*j -: 32];
    end else if (busy_q) begin
      v_q <= v_d;
      w_q <= w_d;
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) hash_o[j] = h_q[j];
  end

  assign stat_o.busy = busy_q | add_q;
  assign stat_o.done = add_q;

endmodule

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 byte-stream hasher.
// Input channel (in_valid_i / in_stall_o): each word is one op_i plus
// data_byte_i. Absorb words append one message byte; a finish word pads the
// message, compresses the tail block(s) and emits the digest.
// Output channel (out_valid_o / out_stall_i): eight words, H0 first, with
// word_index_o counting 0..7 and last_word_o high on the eighth.
// Steps: an absorb word appends its byte; the 64th byte of a block then
// starts the core (start, 64 rounds of the shared round unit, final add).
// A finish word writes the 0x80 marker, then the zero pad bytes up to the
// length field, then the eight length bytes, compresses one or two blocks
// and then delivers the digest.
// in_stall_o is high from the cycle after the 64th byte of a block or a
// finish word is taken until the block is idle again.
// A stalled output holds its word; the block then waits for the receiver.
// After the last digest word is taken the hash words, fill count and bit
// count return to their initial values for the next message.
// Reset (rst_ni low, asynchronous) does the same and empties the channels.
// The message bit count wraps modulo 2^64.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha256_pkg::*;

  localparam logic [5:0] FillLast = 6'd63;
  localparam logic [5:0] LenPos   = 6'd56;  // length field starts here
  localparam logic [7:0] PadMark  = 8'h80;
  localparam logic [2:0] LenLast  = 3'd7;
  localparam logic [2:0] IdxLast  = 3'd7;

  state_e               state_q, state_d;
  logic [5:0]           fill_q, fill_d;
  logic [63:0]          bits_q, bits_d;
  logic [2:0]           len_q, len_d;
  logic [2:0]           idx_q, idx_d;
  logic                 fin_q, fin_d;     // finish in progress
  logic                 final_q, final_d; // length written, last compression
  logic [BlockBits-1:0] blk_q, blk_d;     // byte shift line, first byte ends on top
  logic                 shift_en;
  logic [7:0]           shift_byte;

  core_ctrl_t ctrl;
  core_stat_t stat;
  hash_t      hash;

  sha256_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .block_i (blk_q),
    .stat_o  (stat),
    .hash_o  (hash)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      bits_q  <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
      final_q <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  always_comb begin
    state_d    = state_q;
    bits_d     = bits_q;
    len_d      = len_q;
    idx_d      = idx_q;
    fin_d      = fin_q;
    final_d    = final_q;
    ctrl       = '0;
    shift_en   = 1'b0;
    shift_byte = 8'h00;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_ABSORB) begin
            shift_en   = 1'b1;
            shift_byte = data_byte_i;
            bits_d     = bits_q + 64'd8;
            if (fill_q == FillLast) state_d = ST_START;
          end else begin
            fin_d   = 1'b1;
            state_d = ST_PAD_MARK;
          end
        end
      end
      ST_START: begin
        ctrl.start = 1'b1;
        state_d    = ST_COMP;
      end
      ST_COMP: begin
        if (stat.done) begin
          if (!fin_q)       state_d = ST_IDLE;
          else if (final_q) state_d = ST_OUT;
          else              state_d = ST_PAD_ZERO;
        end
      end
      ST_PAD_MARK: begin
        shift_en   = 1'b1;
        shift_byte = PadMark;
        state_d    = (fill_q == FillLast) ? ST_START : ST_PAD_ZERO;
      end
      ST_PAD_ZERO: begin
        if (fill_q == LenPos) begin
          state_d = ST_PAD_LEN;
        end else begin
          shift_en = 1'b1;
          if (fill_q == FillLast) state_d = ST_START;
        end
      end
      ST_PAD_LEN: begin
        // big-endian length, top byte first
        shift_en   = 1'b1;
        shift_byte = bits_q[63:56];
        bits_d     = {bits_q[55:0], 8'h00};
        len_d      = len_q + 3'd1;
        if (len_q == LenLast) begin
          final_d = 1'b1;
          state_d = ST_START;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == IdxLast) begin
            ctrl.init = 1'b1;
            fin_d     = 1'b0;
            final_d   = 1'b0;
            bits_d    = '0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (shift_en) begin
      blk_d  = {blk_q[BlockBits-9:0], shift_byte};
      fill_d = fill_q + 6'd1;
    end else begin
      blk_d  = blk_q;
      fill_d = fill_q;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = hash[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == IdxLast);

`include "assert_macros.svh"

  `SHA_ASSERT_NEVER(a_start_busy, ctrl.start && stat.busy, "core started while busy")
  `SHA_ASSERT(a_out_fill, (state_q == ST_OUT) |-> (fill_q == 6'd0), "digest with bytes pending")
  `SHA_ASSERT(a_out_vs_in, out_valid_o |-> in_stall_o, "input open during digest")
  `SHA_ASSERT(a_last_idle, (out_valid_o && !out_stall_i && last_word_o) |=> !in_stall_o, "not idle after digest")

endmodule
